FILE: hdl/iebm_pkg.sv
// shared types and constants for the i2c eeprom byte master
// payload structs, configuration struct, action and register codes
// no dependencies
package iebm_pkg;

    // request codes carried in the action field
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TICKS    = 2'd2;

    // configuration reset values
    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd200;
    localparam logic [7:0] PHASE_TICKS_RESET    = 8'd1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       all_acked;
        logic [7:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] ack_timeout;
        logic [7:0] phase_ticks;
    } cfg_set_t;

endpackage

FILE: hdl/iebm_cfg.sv
// configuration register bank for the i2c eeprom byte master
// depends on iebm_pkg
module iebm_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iebm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                          cfg_data,
    output iebm_pkg::cfg_set_t                  cfg_out
);
    import iebm_pkg::*;

    cfg_set_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RESET;
            cfg_reg.ack_timeout    <= ACK_TIMEOUT_RESET;
            cfg_reg.phase_ticks    <= PHASE_TICKS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                CFG_ACK_TIMEOUT:    cfg_reg.ack_timeout    <= cfg_data;
                CFG_PHASE_TICKS:    cfg_reg.phase_ticks    <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/iebm_seq.sv
// bus sequencer: phase state, bit and hold counters, one tick per accepted transaction
// depends on iebm_pkg
module iebm_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  iebm_pkg::in_item_t    tick_in,
    input  iebm_pkg::cfg_set_t    cfg,
    output iebm_pkg::out_item_t   tick_res
);
    import iebm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_SDA_HI, PH_ST_SCL_HI, PH_ST_SDA_LO, PH_ST_SCL_LO,
        PH_TX_SET, PH_TX_HI, PH_TX_LO, PH_TX_REL, PH_ACK_WAIT, PH_ACK_LO,
        PH_RX_REL, PH_RX_SET, PH_RX_HI, PH_RX_LO, PH_NACK_HI, PH_NACK_LO,
        PH_SP_SDA_LO, PH_SP_SCL_HI, PH_SP_SDA_HI
    } phase_t;

    // byte slots within one transaction
    localparam logic [2:0] IDX_DEVICE = 3'd0;
    localparam logic [2:0] IDX_MEMORY = 3'd1;
    localparam logic [2:0] IDX_THIRD  = 3'd2;
    localparam logic [2:0] IDX_LAST   = 3'd3;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    phase_t     phase_reg, phase_next, target;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] hold_count_reg, hold_count_next;
    logic [7:0] ack_wait_reg, ack_wait_next;
    logic [2:0] byte_index_reg, byte_index_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] saved_address_reg, saved_address_next;
    logic [7:0] saved_data_reg, saved_data_next;
    logic       acks_good_reg, acks_good_next;
    logic [7:0] received_reg, received_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       do_enter;
    logic       done;

    // byte to shift out for a given slot
    function automatic logic [7:0] pick_byte(
        input logic [2:0] idx,
        input logic       rd,
        input logic [6:0] dev,
        input logic [7:0] addr,
        input logic [7:0] data
    );
        logic [7:0] dev_byte;
        dev_byte = {dev, 1'b0};
        if (idx == IDX_DEVICE)      pick_byte = dev_byte;
        else if (idx == IDX_MEMORY) pick_byte = addr;
        else if (rd)                pick_byte = dev_byte | 8'd1;
        else                        pick_byte = data;
    endfunction

    // next state for one tick
    always_comb begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shift_byte_next    = shift_byte_reg;
        hold_count_next    = hold_count_reg;
        ack_wait_next      = ack_wait_reg;
        byte_index_next    = byte_index_reg;
        is_read_next       = is_read_reg;
        saved_address_next = saved_address_reg;
        saved_data_next    = saved_data_reg;
        acks_good_next     = acks_good_reg;
        received_next      = received_reg;
        scl_next           = scl_reg;
        sda_next           = sda_reg;
        target             = PH_IDLE;
        do_enter           = 1'b0;
        done               = 1'b0;

        if (phase_reg == PH_IDLE) begin
            // request latch
            if (tick_in.action == ACT_WRITE || tick_in.action == ACT_READ) begin
                is_read_next       = (tick_in.action == ACT_READ);
                saved_address_next = tick_in.mem_address;
                saved_data_next    = tick_in.write_data;
                acks_good_next     = 1'b1;
                byte_index_next    = IDX_DEVICE;
                bit_count_next     = '0;
                target             = PH_ST_SDA_HI;
                do_enter           = 1'b1;
            end
        end else if (phase_reg == PH_ACK_WAIT) begin
            // acknowledge wait with timeout
            if (!tick_in.sda_in) begin
                target   = PH_ACK_LO;
                do_enter = 1'b1;
            end else if (ack_wait_reg >= cfg.ack_timeout) begin
                acks_good_next = 1'b0;
                target         = PH_ACK_LO;
                do_enter       = 1'b1;
            end else begin
                ack_wait_next = ack_wait_reg + 8'd1;
            end
        end else if (hold_count_reg < cfg.phase_ticks) begin
            hold_count_next = hold_count_reg + 8'd1;
        end else begin
            // end of a held step
            do_enter = 1'b1;
            unique case (phase_reg)
                PH_ST_SDA_HI: target = PH_ST_SCL_HI;
                PH_ST_SCL_HI: target = PH_ST_SDA_LO;
                PH_ST_SDA_LO: target = PH_ST_SCL_LO;
                PH_ST_SCL_LO: begin
                    shift_byte_next = pick_byte(byte_index_reg, is_read_reg,
                        cfg.device_address, saved_address_reg, saved_data_reg);
                    bit_count_next  = '0;
                    target          = PH_TX_SET;
                end
                PH_TX_SET: target = PH_TX_HI;
                PH_TX_HI:  target = PH_TX_LO;
                PH_TX_LO: begin
                    shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    bit_count_next  = bit_count_reg + 4'd1;
                    target = (bit_count_next >= BITS_PER_BYTE) ? PH_TX_REL : PH_TX_SET;
                end
                PH_TX_REL: target = PH_ACK_WAIT;
                PH_ACK_LO: begin
                    byte_index_next = byte_index_reg + 3'd1;
                    if (is_read_reg && byte_index_next == IDX_THIRD) begin
                        target = PH_ST_SDA_HI;
                    end else if (is_read_reg && byte_index_next >= IDX_LAST) begin
                        target = PH_RX_REL;
                    end else if (!is_read_reg && byte_index_next >= IDX_LAST) begin
                        target = PH_SP_SDA_LO;
                    end else begin
                        shift_byte_next = pick_byte(byte_index_next, is_read_reg,
                            cfg.device_address, saved_address_reg, saved_data_reg);
                        bit_count_next  = '0;
                        target          = PH_TX_SET;
                    end
                end
                PH_RX_REL: target = PH_RX_SET;
                PH_RX_SET: target = PH_RX_HI;
                PH_RX_HI: begin
                    shift_byte_next = {shift_byte_reg[6:0], tick_in.sda_in};
                    target          = PH_RX_LO;
                end
                PH_RX_LO: begin
                    bit_count_next = bit_count_reg + 4'd1;
                    if (bit_count_next >= BITS_PER_BYTE) begin
                        received_next = shift_byte_reg;
                        target        = PH_NACK_HI;
                    end else begin
                        target = PH_RX_SET;
                    end
                end
                PH_NACK_HI:   target = PH_NACK_LO;
                PH_NACK_LO:   target = PH_SP_SDA_LO;
                PH_SP_SDA_LO: target = PH_SP_SCL_HI;
                PH_SP_SCL_HI: target = PH_SP_SDA_HI;
                PH_SP_SDA_HI: begin
                    target = PH_IDLE;
                    done   = 1'b1;
                end
                default: target = PH_IDLE;
            endcase
        end

        // line levels set on entry to a step
        if (do_enter) begin
            phase_next      = target;
            hold_count_next = 8'd1;
            unique case (target)
                PH_ST_SDA_HI: sda_next = 1'b1;
                PH_ST_SCL_HI: scl_next = 1'b1;
                PH_ST_SDA_LO: sda_next = 1'b0;
                PH_ST_SCL_LO: scl_next = 1'b0;
                PH_TX_SET: begin
                    scl_next = 1'b0;
                    sda_next = shift_byte_next[7];
                end
                PH_TX_HI:  scl_next = 1'b1;
                PH_TX_LO:  scl_next = 1'b0;
                PH_TX_REL: sda_next = 1'b1;
                PH_ACK_WAIT: begin
                    scl_next      = 1'b1;
                    ack_wait_next = '0;
                end
                PH_ACK_LO: scl_next = 1'b0;
                PH_RX_REL: begin
                    sda_next        = 1'b1;
                    shift_byte_next = '0;
                    bit_count_next  = '0;
                end
                PH_RX_SET: ;
                PH_RX_HI:  scl_next = 1'b1;
                PH_RX_LO:  scl_next = 1'b0;
                PH_NACK_HI: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_NACK_LO:   scl_next = 1'b0;
                PH_SP_SDA_LO: sda_next = 1'b0;
                PH_SP_SCL_HI: scl_next = 1'b1;
                PH_SP_SDA_HI: sda_next = 1'b1;
                default: begin
                    phase_next = PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
            endcase
        end
    end

    // result of this tick
    always_comb begin
        tick_res.scl_level = scl_next;
        tick_res.sda_level = sda_next;
        tick_res.busy_res  = (phase_next != PH_IDLE);
        tick_res.done_res  = done;
        tick_res.all_acked = acks_good_next;
        tick_res.read_data = received_next;
    end

    // sequencer state, advanced once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            shift_byte_reg    <= '0;
            hold_count_reg    <= '0;
            ack_wait_reg      <= '0;
            byte_index_reg    <= '0;
            is_read_reg       <= 1'b0;
            saved_address_reg <= '0;
            saved_data_reg    <= '0;
            acks_good_reg     <= 1'b1;
            received_reg      <= '0;
            scl_reg           <= 1'b1;
            sda_reg           <= 1'b1;
        end else if (step_en) begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            shift_byte_reg    <= shift_byte_next;
            hold_count_reg    <= hold_count_next;
            ack_wait_reg      <= ack_wait_next;
            byte_index_reg    <= byte_index_next;
            is_read_reg       <= is_read_next;
            saved_address_reg <= saved_address_next;
            saved_data_reg    <= saved_data_next;
            acks_good_reg     <= acks_good_next;
            received_reg      <= received_next;
            scl_reg           <= scl_next;
            sda_reg           <= sda_next;
        end
    end

endmodule

FILE: hdl/iebm_out_reg.sv
// result register between the sequencer and the result channel
// depends on iebm_pkg
module iebm_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  iebm_pkg::out_item_t   res_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output iebm_pkg::out_item_t   m_data
);
    import iebm_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    // room when empty or when the held result leaves this cycle
    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= res_in;
        end
    end

endmodule

FILE: hdl/i2c_eeprom_byte_master_unit.sv
// Tick-driven I2C master for a serial EEPROM: byte write and random read.
// Every input transaction is one bus tick and yields exactly one result in the
// result register in the following cycle; a tick is accepted in every cycle while
// the result register is empty or being drained, so throughput is one tick per
// clock. The sequencer state advances only on accepted ticks, so stalls on either
// side do not disturb bus timing in tick terms.
// Depends on iebm_pkg, iebm_cfg, iebm_seq and iebm_out_reg.
module i2c_eeprom_byte_master_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  iebm_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output iebm_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iebm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                          cfg_data
);
    import iebm_pkg::*;

    cfg_set_t  cfg;
    out_item_t tick_res;
    logic      step_en;

    assign step_en = s_valid && s_ready;

    // configuration registers
    iebm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    // bus sequencer
    iebm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .tick_in  (s_data),
        .cfg      (cfg),
        .tick_res (tick_res)
    );

    // result register
    iebm_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .res_in  (tick_res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // an accepted tick always leaves a result behind
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted tick produced no result");

    // completion and busy never reported together
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.done_res && m_data.busy_res))
        else $error("done reported while still busy");

    // stop condition leaves both lines released
    a_done_lines_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> (m_data.scl_level && m_data.sda_level))
        else $error("lines not released at stop completion");

endmodule
